/* hdl/tlgl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlgl_pkg;

    // Input operations
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_CODE    = 2'd2;
    localparam logic [1:0] OP_METRICS = 2'd3;

    // Result kinds
    localparam logic KIND_GLYPH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd2;

    localparam logic [7:0]  ESCAPE_RESET = 8'd255;
    localparam logic [9:0]  COUNT_RESET  = 10'd0;
    localparam logic [11:0] SCREEN_RESET = 12'd256;
    localparam logic [11:0] PEN_MAX      = 12'd4095;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_LOW  = 2'd1,
        ESC_HIGH = 2'd2
    } t_esc_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_META_RD,
        ST_META,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  text_byte;
        logic [11:0] start_x;
        logic [8:0]  entry_index;
        logic [15:0] char_code;
        logic [11:0] tex_u;
        logic [11:0] tex_v;
        logic [7:0]  glyph_w;
        logic [7:0]  glyph_h;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [8:0]         glyph_index;
        logic               found;
        logic [11:0]        pen_x;
        logic [11:0]        out_tex_u;
        logic [11:0]        out_tex_v;
        logic [7:0]         out_width;
        logic [7:0]         out_height;
        logic [11:0]        sum_width;
        logic signed [11:0] centered_x;
    } t_out_item;

    typedef struct packed {
        logic [11:0] u;
        logic [11:0] v;
        logic [7:0]  w;
        logic [7:0]  h;
    } t_metrics;

    typedef struct packed {
        logic accept;
        logic search;
        logic emit_glyph;
        logic emit_summary;
    } t_dp_cmd;

    typedef struct packed {
        logic want_place;
        logic want_summary;
        logic cnt_zero;
        logic search_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/tlgl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlgl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/tlgl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlgl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tlgl_pkg::t_dp_stat i_stat,
    output tlgl_pkg::t_dp_cmd       o_cmd
);

    import tlgl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_stat.want_place) begin
                        n_state = i_stat.cnt_zero ? ST_META_RD : ST_SEARCH;
                    end else if (i_stat.want_summary) begin
                        n_state = ST_SUMMARY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = ST_META_RD;
                end
            end
            ST_META_RD: begin
                n_state = ST_META;
            end
            ST_META: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUMMARY: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            ST_META: begin
                o_cmd.emit_glyph = i_stat.out_free;
            end
            ST_SUMMARY: begin
                o_cmd.emit_summary = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tlgl_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlgl_dp #(
    parameter int TABLE_DEPTH = 512,
    parameter int CODE_BITS   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tlgl_pkg::t_in_item                  i_in,
    input  wire logic                                i_cfg_we,
    input  wire logic [tlgl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tlgl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire tlgl_pkg::t_dp_cmd                   i_cmd,
    output tlgl_pkg::t_dp_stat                       o_stat,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output tlgl_pkg::t_out_item                      o_out
);

    import tlgl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int BW    = $clog2(TABLE_DEPTH + 1);

    // Configuration
    logic [7:0]  r_escape_byte;
    logic [9:0]  r_glyph_count;
    logic [11:0] r_screen_width;

    // String state
    logic [11:0] r_pen;
    logic [11:0] r_sum;
    t_esc_phase  r_phase;
    t_esc_phase  n_phase;
    logic [7:0]  r_pending;
    logic [7:0]  n_pending;

    // Search state
    logic [CODE_BITS-1:0] r_code;
    logic [BW-1:0]        r_lo;
    logic [BW-1:0]        r_hi1;
    logic [IDX_W-1:0]     r_mid;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_found;

    logic      r_out_valid;
    t_out_item r_out;

    logic                 want_place;
    logic                 want_summary;
    logic [15:0]          code_raw;
    logic [BW-1:0]        cnt;
    logic [BW-1:0]        cnt_m1;
    logic [IDX_W-1:0]     init_mid;
    logic [CODE_BITS-1:0] code_rd;
    logic                 hit;
    logic                 less;
    logic [BW-1:0]        mid_ext;
    logic [BW-1:0]        n_lo;
    logic [BW-1:0]        n_hi1;
    logic                 more;
    logic [BW:0]          mid_sum;
    logic [IDX_W-1:0]     n_mid;
    logic [IDX_W-1:0]     code_raddr;
    logic                 idx_ok;
    logic [IDX_W-1:0]     waddr;
    logic                 code_we;
    logic                 meta_we;
    t_metrics             meta_wr;
    t_metrics             meta_rd;
    logic [12:0]          pen_add;
    logic [12:0]          sum_add;
    logic [11:0]          n_pen;
    logic [11:0]          n_sum;
    logic signed [12:0]   diff;
    logic signed [12:0]   half;
    logic                 out_free;
    t_out_item            glyph_item;
    t_out_item            summary_item;

    // Escape decoding of one text byte
    always_comb begin
        want_place   = 1'b0;
        want_summary = 1'b0;
        n_phase      = r_phase;
        n_pending    = r_pending;
        code_raw     = {8'h00, i_in.text_byte};
        if (i_in.opcode == OP_TEXT) begin
            unique case (r_phase)
                ESC_LOW: begin
                    n_pending = i_in.text_byte;
                    n_phase   = ESC_HIGH;
                end
                ESC_HIGH: begin
                    n_phase    = ESC_NONE;
                    want_place = 1'b1;
                    code_raw   = {i_in.text_byte, r_pending};
                end
                default: begin
                    n_phase = ESC_NONE;
                    priority if (i_in.text_byte == 8'h00) begin
                        want_summary = 1'b1;
                    end else if (i_in.text_byte == r_escape_byte) begin
                        n_phase = ESC_LOW;
                    end else begin
                        want_place = 1'b1;
                    end
                end
            endcase
        end
    end

    // Search bounds kept as lo and hi+1
    assign cnt      = (32'(r_glyph_count) > TABLE_DEPTH) ? BW'(TABLE_DEPTH)
                                                         : BW'(r_glyph_count);
    assign cnt_m1   = cnt - BW'(1);
    assign init_mid = IDX_W'(cnt_m1 >> 1);

    assign hit     = (code_rd == r_code);
    assign less    = (code_rd < r_code);
    assign mid_ext = BW'(r_mid);
    assign n_lo    = less ? (mid_ext + BW'(1)) : r_lo;
    assign n_hi1   = less ? r_hi1 : mid_ext;
    assign more    = (n_lo < n_hi1);
    assign mid_sum = {1'b0, n_lo} + {1'b0, n_hi1} - (BW + 1)'(1);
    assign n_mid   = IDX_W'(mid_sum >> 1);

    // Issue the next probe in the same cycle the current one is compared
    assign code_raddr = i_cmd.search ? n_mid : init_mid;

    // Table loads
    assign idx_ok  = (32'(i_in.entry_index) < TABLE_DEPTH);
    assign waddr   = IDX_W'(i_in.entry_index);
    assign code_we = i_cmd.accept && (i_in.opcode == OP_CODE) && idx_ok;
    assign meta_we = i_cmd.accept && (i_in.opcode == OP_METRICS) && idx_ok;
    assign meta_wr = '{u: i_in.tex_u, v: i_in.tex_v, w: i_in.glyph_w, h: i_in.glyph_h};

    tlgl_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (waddr),
        .i_wdata (i_in.char_code[CODE_BITS-1:0]),
        .i_raddr (code_raddr),
        .o_rdata (code_rd)
    );

    tlgl_ram #(
        .WIDTH ($bits(t_metrics)),
        .DEPTH (TABLE_DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (waddr),
        .i_wdata (meta_wr),
        .i_raddr (r_idx),
        .o_rdata (meta_rd)
    );

    // Saturating pen and width sum
    assign pen_add = {1'b0, r_pen} + 13'(meta_rd.w);
    assign sum_add = {1'b0, r_sum} + 13'(meta_rd.w);
    assign n_pen   = pen_add[12] ? PEN_MAX : pen_add[11:0];
    assign n_sum   = sum_add[12] ? PEN_MAX : sum_add[11:0];

    // Halve with truncation toward zero
    assign diff = $signed({1'b0, r_screen_width}) - $signed({1'b0, r_sum});
    assign half = (diff + $signed({12'd0, diff[12]})) >>> 1;

    always_comb begin
        glyph_item             = '0;
        glyph_item.kind        = KIND_GLYPH;
        glyph_item.glyph_index = 9'(r_idx);
        glyph_item.found       = r_found;
        glyph_item.pen_x       = r_pen;
        glyph_item.out_tex_u   = meta_rd.u;
        glyph_item.out_tex_v   = meta_rd.v;
        glyph_item.out_width   = meta_rd.w;
        glyph_item.out_height  = meta_rd.h;

        summary_item            = '0;
        summary_item.kind       = KIND_SUMMARY;
        summary_item.sum_width  = r_sum;
        summary_item.centered_x = half[11:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte  <= ESCAPE_RESET;
            r_glyph_count  <= COUNT_RESET;
            r_screen_width <= SCREEN_RESET;
            r_pen          <= '0;
            r_sum          <= '0;
            r_phase        <= ESC_NONE;
            r_pending      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ESCAPE_BYTE:  r_escape_byte  <= i_cfg_data[7:0];
                    CFG_GLYPH_COUNT:  r_glyph_count  <= i_cfg_data[9:0];
                    CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                unique case (i_in.opcode)
                    OP_START: begin
                        r_pen     <= i_in.start_x;
                        r_sum     <= '0;
                        r_phase   <= ESC_NONE;
                        r_pending <= '0;
                    end
                    OP_TEXT: begin
                        r_phase   <= n_phase;
                        r_pending <= n_pending;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit_glyph) begin
                r_pen <= n_pen;
                r_sum <= n_sum;
            end
            if (i_cmd.emit_glyph || i_cmd.emit_summary) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && want_place) begin
            r_code  <= code_raw[CODE_BITS-1:0];
            r_lo    <= '0;
            r_hi1   <= cnt;
            r_mid   <= init_mid;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.search) begin
            if (hit) begin
                r_idx   <= r_mid;
                r_found <= 1'b1;
            end else begin
                r_lo  <= n_lo;
                r_hi1 <= n_hi1;
                r_mid <= n_mid;
            end
        end
        if (i_cmd.emit_glyph) begin
            r_out <= glyph_item;
        end else if (i_cmd.emit_summary) begin
            r_out <= summary_item;
        end
    end

    assign o_stat.want_place   = want_place;
    assign o_stat.want_summary = want_summary;
    assign o_stat.cnt_zero     = (cnt == '0);
    assign o_stat.search_done  = hit || !more;
    assign o_stat.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* hdl/text_layout_glyph_lookup_top.sv */
// Text layout with glyph lookup.
// Input channel (i_in_valid / o_in_ready, word i_in): one operation per word.
// Start and table loads finish on acceptance; a text byte either updates the
// escape progress, ends the string with a summary word, or places one glyph.
// Configuration words (i_cfg_*) are taken on any cycle out of reset; both
// input channels stay closed while reset is held.
// Output channel (o_out_valid / i_out_ready, word o_out): one result word,
// held in an output register so the receiver may stall it freely.
// Glyph placement: the code table is probed once per cycle, since each
// probe's compare picks the next address on the single read port of the code
// memory; up to ceil(log2(count+1)) probes (10 for 512 entries). Accept
// comes before the search; the metrics read and the output load follow it.
// One word is in flight at a time; the input channel reopens once the result
// is in the output register.
// If the receiver stalls, the block holds its result and waits before
// loading the next one. Reset clears the configuration to its defaults, the
// pen, width sum and escape progress, and empties the output register;
// table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module text_layout_glyph_lookup_top #(
    parameter int TABLE_DEPTH = 512,
    parameter int CODE_BITS   = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire tlgl_pkg::t_in_item              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output tlgl_pkg::t_out_item                  o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tlgl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tlgl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import tlgl_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Registers are writable on any cycle out of reset
    assign o_cfg_ready = i_rst_n;

    // Sequencer: accept, search, metrics read, emit
    tlgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Tables, search bounds, pen and output register
    tlgl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_BITS   (CODE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* hdl/tlgl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlgl_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire tlgl_pkg::t_in_item  i_in,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tlgl_pkg::t_out_item o_out
);

    import tlgl_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Start and loads never close the input channel
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.opcode != OP_TEXT |=> o_in_ready)
        else $error("non-text word stalled the input");

    a_summary_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_SUMMARY |->
            !o_out.found && o_out.glyph_index == '0 && o_out.pen_x == '0
            && o_out.out_width == '0 && o_out.out_height == '0)
        else $error("summary carries glyph fields");

    a_glyph_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_GLYPH |->
            o_out.sum_width == '0 && o_out.centered_x == '0
            && (o_out.found || o_out.glyph_index == '0))
        else $error("glyph result fields inconsistent");

endmodule

bind text_layout_glyph_lookup_top tlgl_checker u_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

// Text layout glyph lookup testbench.
//
// A queue of pending operations (input words and register writes) is filled by
// the stimulus process at falling edges. A clocked driver offers the words on
// the input channel and, once the block has gone quiet, the register writes on
// the configuration channel. At every accepted input word the driver steps a
// local model of the layout engine (escape decoding, binary search, pen and
// width sums, centering) and queues the result word it must produce. A clocked
// monitor pops that queue on every accepted output word and compares it field
// by field.
module tb_top;

    import tlgl_pkg::*;

    localparam int TAB_DEPTH    = 512;
    localparam int BIG_TABLE    = 128;  // largest table loaded in one phase
    localparam int CFG_QUIET    = 20;   // idle cycles before a register write
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int DRAIN_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;

    // One pending operation: either an input word or a register write.
    typedef struct {
        bit                    is_cfg;
        t_in_item              word;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim;

    // Clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Block ports, all driven to known values from time zero
    logic                  in_valid  = 1'b0;
    t_in_item              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic                  o_cfg_ready;

    text_layout_glyph_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Pending operations and expected result words
    t_stim     op_backlog[$];
    t_out_item layout_due[$];

    // Idling knobs; all but hold_left are set by the stimulus process at falling edges
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   hold_left      = 0;

    // Bookkeeping
    int results_due     = 0;   // driver side: results predicted
    int results_done    = 0;   // monitor side: results popped (nonblocking)
    int quiet           = 0;
    int words_taken     = 0;
    int cfg_writes      = 0;
    int words_queued    = 0;
    int bad_words       = 0;
    int glyphs_seen     = 0;
    int summaries_seen  = 0;
    int hits_seen       = 0;

    // ------------------------------------------------------------------
    // Layout model state
    // ------------------------------------------------------------------
    logic [15:0] code_tab [TAB_DEPTH];
    t_metrics    met_tab  [TAB_DEPTH];
    logic [11:0] pen       = '0;
    logic [11:0] wsum      = '0;
    t_esc_phase  esc_ph    = ESC_NONE;
    logic [7:0]  low_byte  = '0;
    logic [7:0]  esc_byte  = ESCAPE_RESET;
    logic [9:0]  glyph_cnt = COUNT_RESET;
    logic [11:0] screen_w  = SCREEN_RESET;

    function automatic logic [11:0] sat12(input int s);
        return (s > 4095) ? PEN_MAX : 12'(s);
    endfunction

    // Binary search over entries 0 .. count-1; a miss resolves to entry 0.
    function automatic logic [8:0] find_glyph(input logic [15:0] code, output bit hit);
        int n, lo, hi, mid;
        n   = (glyph_cnt > TAB_DEPTH) ? TAB_DEPTH : int'(glyph_cnt);
        lo  = 0;
        hi  = n - 1;
        hit = 1'b0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (code_tab[mid] == code) begin
                hit = 1'b1;
                return 9'(mid);
            end
            if (code_tab[mid] < code)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return '0;
    endfunction

    task automatic place_glyph(input logic [15:0] code, output t_out_item r);
        bit          hit;
        logic [8:0]  gi;
        t_metrics    m;
        gi            = find_glyph(code, hit);
        m             = met_tab[gi];
        r             = '0;
        r.kind        = KIND_GLYPH;
        r.glyph_index = gi;
        r.found       = hit;
        r.pen_x       = pen;
        r.out_tex_u   = m.u;
        r.out_tex_v   = m.v;
        r.out_width   = m.w;
        r.out_height  = m.h;
        pen           = sat12(int'(pen) + int'(m.w));
        wsum          = sat12(int'(wsum) + int'(m.w));
    endtask

    // Advance the model by one accepted input word.
    task automatic layout_step(input t_in_item w);
        t_out_item r;
        bit        emit;
        int        diff;
        r    = '0;
        emit = 1'b0;
        case (w.opcode)
            OP_START: begin
                pen      = w.start_x;
                wsum     = '0;
                esc_ph   = ESC_NONE;
                low_byte = '0;
            end
            OP_CODE:    code_tab[w.entry_index] = w.char_code;
            OP_METRICS: met_tab[w.entry_index] = {w.tex_u, w.tex_v, w.glyph_w, w.glyph_h};
            default: begin
                if (esc_ph == ESC_LOW) begin
                    low_byte = w.text_byte;
                    esc_ph   = ESC_HIGH;
                end else if (esc_ph == ESC_HIGH) begin
                    // zero here is a code byte, not a terminator
                    esc_ph = ESC_NONE;
                    place_glyph({w.text_byte, low_byte}, r);
                    emit = 1'b1;
                end else if (w.text_byte == 8'd0) begin
                    diff         = int'(screen_w) - int'(wsum);
                    r.kind       = KIND_SUMMARY;
                    r.sum_width  = wsum;
                    r.centered_x = 12'(diff / 2);
                    emit         = 1'b1;
                end else if (w.text_byte == esc_byte) begin
                    esc_ph = ESC_LOW;
                end else begin
                    place_glyph({8'd0, w.text_byte}, r);
                    emit = 1'b1;
                end
            end
        endcase
        if (emit) begin
            layout_due.push_back(r);
            results_due++;
        end
    endtask

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ESCAPE_BYTE:  esc_byte  = data[7:0];
            CFG_GLYPH_COUNT:  glyph_cnt = data[9:0];
            CFG_SCREEN_WIDTH: screen_w  = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending words; hold each until accepted. Register
    // writes wait until every expected word is back and the block has
    // been quiet long enough to finish any word that has no result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_stim                 head;
        logic                  nxt_valid;
        logic                  nxt_cfg_valid;
        t_in_item              nxt_word;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            quiet     = 0;
        end else begin
            nxt_valid     = in_valid;
            nxt_word      = in_word;
            nxt_cfg_valid = cfg_valid;
            nxt_idx       = cfg_idx;
            nxt_data      = cfg_data;

            if (in_valid && o_in_ready) begin
                layout_step(in_word);
                words_taken++;
                nxt_valid = 1'b0;
                quiet     = 0;
            end else if (results_done < results_due) begin
                quiet = 0;
            end else if (quiet < CFG_QUIET) begin
                quiet++;
            end

            if (cfg_valid && o_cfg_ready) begin
                apply_cfg(cfg_idx, cfg_data);
                cfg_writes++;
                nxt_cfg_valid = 1'b0;
            end

            // Pick the next operation only when both channels are free
            if (!nxt_valid && !nxt_cfg_valid && op_backlog.size() != 0) begin
                head = op_backlog[0];
                if (head.is_cfg) begin
                    if (quiet >= CFG_QUIET) begin
                        nxt_cfg_valid = 1'b1;
                        nxt_idx       = head.idx;
                        nxt_data      = head.data;
                        void'(op_backlog.pop_front());
                    end
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    nxt_valid = 1'b1;
                    nxt_word  = head.word;
                    void'(op_backlog.pop_front());
                end
            end

            in_valid  <= nxt_valid;
            in_word   <= nxt_word;
            cfg_valid <= nxt_cfg_valid;
            cfg_idx   <= nxt_idx;
            cfg_data  <= nxt_data;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted result word against the oldest
    // expectation, then pick the next ready.
    // ------------------------------------------------------------------
    function automatic string field_diffs(input t_out_item e, input t_out_item g);
        string s;
        s = "";
        if (g.kind        !== e.kind)        s = {s, " kind"};
        if (g.glyph_index !== e.glyph_index) s = {s, " glyph_index"};
        if (g.found       !== e.found)       s = {s, " found"};
        if (g.pen_x       !== e.pen_x)       s = {s, " pen_x"};
        if (g.out_tex_u   !== e.out_tex_u)   s = {s, " out_tex_u"};
        if (g.out_tex_v   !== e.out_tex_v)   s = {s, " out_tex_v"};
        if (g.out_width   !== e.out_width)   s = {s, " out_width"};
        if (g.out_height  !== e.out_height)  s = {s, " out_height"};
        if (g.sum_width   !== e.sum_width)   s = {s, " sum_width"};
        if (g.centered_x  !== e.centered_x)  s = {s, " centered_x"};
        return s;
    endfunction

    task automatic flag_word(input string why, input t_out_item want,
                             input t_out_item got, input string fields);
        bad_words++;
        if (bad_words <= 10)
            $display("[%0t] %s: expected %h got %h%s", $time, why, want, got, fields);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        string     diffs;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (layout_due.size() == 0) begin
                    flag_word("result word with nothing expected", '0, o_out, "");
                end else begin
                    want         = layout_due.pop_front();
                    results_done <= results_done + 1;
                    diffs        = field_diffs(want, o_out);
                    if (diffs != "")
                        flag_word("result word mismatch, fields", want, o_out, diffs);
                    if (want.kind == KIND_SUMMARY) begin
                        summaries_seen++;
                    end else begin
                        glyphs_seen++;
                        if (want.found)
                            hits_seen++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps going
    always @(posedge i_clk) begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus generation (runs at falling edges, zero time per batch)
    // ------------------------------------------------------------------
    logic [7:0]  gen_esc   = ESCAPE_RESET;
    int          gen_count = 0;
    logic [15:0] gen_codes[$];

    function automatic t_in_item random_word(input logic [1:0] op);
        logic [95:0] bits;
        t_in_item    w;
        bits     = {$urandom(), $urandom(), $urandom()};
        w        = bits[$bits(t_in_item)-1:0];
        w.opcode = op;
        return w;
    endfunction

    task automatic push_word(input t_in_item w);
        op_backlog.push_back('{is_cfg: 1'b0, word: w, idx: '0, data: '0});
        words_queued++;
    endtask

    task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        op_backlog.push_back('{is_cfg: 1'b1, word: '0, idx: idx, data: data});
        if (idx == CFG_ESCAPE_BYTE)
            gen_esc = data[7:0];
        else if (idx == CFG_GLYPH_COUNT)
            gen_count = int'(data[9:0]);
    endtask

    task automatic put_text(input logic [7:0] b);
        t_in_item w;
        w           = random_word(OP_TEXT);
        w.text_byte = b;
        push_word(w);
    endtask

    task automatic put_start(input logic [11:0] x);
        t_in_item w;
        w         = random_word(OP_START);
        w.start_x = x;
        push_word(w);
    endtask

    task automatic put_load(input logic [8:0] idx, input logic [15:0] code, input t_metrics m);
        t_in_item w;
        w             = random_word(OP_CODE);
        w.entry_index = idx;
        w.char_code   = code;
        push_word(w);
        w             = random_word(OP_METRICS);
        w.entry_index = idx;
        w.tex_u       = m.u;
        w.tex_v       = m.v;
        w.glyph_w     = m.w;
        w.glyph_h     = m.h;
        push_word(w);
    endtask

    // Send one character: plain byte where possible, otherwise escaped if the escape byte is nonzero.
    task automatic put_code(input logic [15:0] code);
        if (code != 16'd0 && code < 16'd256 && code[7:0] != gen_esc) begin
            put_text(code[7:0]);
        end else if (gen_esc != 8'd0) begin
            put_text(gen_esc);
            put_text(code[7:0]);
            put_text(code[15:8]);
        end else begin
            // no escape possible with a zero escape byte
            put_text(8'($urandom_range(1, 255)));
        end
    endtask

    function automatic logic [11:0] pick_x();
        case ($urandom_range(3))
            0:       return 12'd0;
            1:       return PEN_MAX;
            default: return 12'($urandom());
        endcase
    endfunction

    // Fill entries 0 .. n-1 with a sorted code table and random metrics.
    task automatic load_table(input int n);
        int          codes[$];
        logic [63:0] mb;
        t_metrics    m;
        codes = {};
        repeat (n)
            codes.push_back($urandom_range(1) ? $urandom_range(1, 255) : $urandom_range(65535));
        codes.sort();
        gen_codes = {};
        foreach (codes[i]) begin
            mb = {$urandom(), $urandom()};
            m  = mb[39:0];
            if ($urandom_range(7) == 0)
                m.w = 8'hFF;
            put_load(9'(i), 16'(codes[i]), m);
            gen_codes.push_back(16'(codes[i]));
        end
    endtask

    // A well-formed string, mostly codes from the table
    task automatic put_string();
        int n;
        int limit;
        if ($urandom_range(3) != 0)
            put_start(pick_x());
        n     = $urandom_range(0, 12);
        limit = (gen_count < gen_codes.size()) ? gen_count : gen_codes.size();
        repeat (n) begin
            if (limit > 0 && $urandom_range(9) < 8)
                put_code(gen_codes[$urandom_range(limit - 1)]);
            else if ($urandom_range(1))
                put_code(16'($urandom_range(1, 255)));
            else
                put_code(16'($urandom()));
        end
        if ($urandom_range(9) != 0)
            put_text(8'd0);
    endtask

    // Noise and broken sequences
    task automatic put_noise();
        logic [15:0] code;
        code = 16'($urandom());
        case ($urandom_range(4))
            0: push_word(random_word(2'($urandom_range(3))));
            1: begin
                // zero bytes inside an escape
                put_text(gen_esc);
                put_text(8'd0);
                put_text(8'd0);
            end
            2: begin
                // start abandons a pending escape
                put_text(gen_esc);
                put_start(pick_x());
                put_text(code[7:0]);
            end
            3: begin
                // loads in the middle of an escape
                put_text(gen_esc);
                push_word(random_word(OP_METRICS));
                put_text(code[7:0]);
                push_word(random_word(OP_CODE));
                put_text(code[15:8]);
            end
            default: put_text(8'($urandom()));
        endcase
    endtask

    task automatic run_random(input int target);
        int mark;
        mark = words_queued;
        while (words_queued - mark < target) begin
            if ($urandom_range(9) < 8)
                put_string();
            else
                put_noise();
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (op_backlog.size() != 0 || in_valid || cfg_valid || layout_due.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: extremes of metrics, miss with empty table, saturation,
        // escaped codes (escape byte itself, all-ones, zero inside escape),
        // zero escape byte ending the string, negative centering.
        set_idling(0, 0);
        put_load(9'd0, 16'h0041, t_metrics'{12'hFFF, 12'h000, 8'hFF, 8'h00});
        put_load(9'd1, 16'h00FF, t_metrics'{12'h000, 12'hFFF, 8'h00, 8'hFF});
        put_load(9'd2, 16'hFFFF, t_metrics'{12'hABC, 12'h123, 8'h11, 8'h7F});
        put_start(12'd100);
        put_text(8'h41);
        put_text(8'h00);
        put_cfg(CFG_GLYPH_COUNT, 12'd3);
        put_start(PEN_MAX);
        put_text(8'h41);
        put_code(16'h00FF);
        put_code(16'hFFFF);
        put_code(16'h0000);
        put_text(8'h00);
        put_cfg(CFG_ESCAPE_BYTE, 12'd0);
        put_cfg(CFG_SCREEN_WIDTH, 12'd0);
        put_start(12'd0);
        put_text(8'h41);
        put_text(8'h00);
        wait_drained();

        // Random phases, most with their own table and register settings
        set_idling(0, 0);
        load_table(16);
        put_cfg(CFG_ESCAPE_BYTE, 12'd255);
        put_cfg(CFG_SCREEN_WIDTH, SCREEN_RESET);
        put_cfg(CFG_GLYPH_COUNT, 12'd16);
        run_random(70);
        wait_drained();

        set_idling(55, 0);
        load_table(40);
        put_cfg(CFG_ESCAPE_BYTE, 12'($urandom_range(1, 254)));
        put_cfg(CFG_GLYPH_COUNT, 12'd33);
        put_cfg(CFG_SCREEN_WIDTH, PEN_MAX);
        run_random(70);
        wait_drained();

        set_idling(0, 55);
        load_table(BIG_TABLE);
        put_cfg(CFG_ESCAPE_BYTE, 12'h01B);
        put_cfg(CFG_GLYPH_COUNT, 12'(BIG_TABLE));
        put_cfg(CFG_SCREEN_WIDTH, 12'($urandom()));
        run_random(70);
        wait_drained();

        // Hold the receiver off while the sender keeps offering words
        set_idling(0, 0);
        hold_req = 1'b1;
        @(negedge i_clk);
        hold_req = 1'b0;
        run_random(40);
        wait_drained();

        set_idling(32, 32);
        load_table(5);
        put_cfg(CFG_ESCAPE_BYTE, 12'd0);
        put_cfg(CFG_GLYPH_COUNT, 12'd5);
        put_cfg(CFG_SCREEN_WIDTH, 12'($urandom()));
        run_random(70);
        wait_drained();

        put_cfg(CFG_ESCAPE_BYTE, 12'd255);
        put_cfg(CFG_GLYPH_COUNT, 12'd0);
        put_cfg(CFG_SCREEN_WIDTH, 12'd0);
        run_random(60);

        // Drain: everything sent, then wait for the last results
        do @(negedge i_clk);
        while (op_backlog.size() != 0 || in_valid || cfg_valid);
        for (int k = 0; k < DRAIN_LIMIT && layout_due.size() != 0; k++)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (layout_due.size() != 0) begin
            $display("%0d expected result words never arrived", layout_due.size());
            bad_words += layout_due.size();
        end

        $display("Run covered %0d input words and %0d register writes across six settings",
                 words_taken, cfg_writes);
        $display("Checked %0d glyph placements (%0d found) and %0d string summaries, %0d bad",
                 glyphs_seen, hits_seen, summaries_seen, bad_words);
        if (bad_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #1500000;
        $display("Timeout: block stopped responding");
        $display("== FAIL ==");
        $finish;
    end

endmodule
